// ===== hw/rtl/mpd_pkg.sv =====
package mpd_pkg;

  // field widths
  localparam int unsigned FrameW  = 32;
  localparam int unsigned PidW    = 16;
  localparam int unsigned IdxW    = 10;
  localparam int unsigned JointW  = 8;
  localparam int unsigned TotalW  = 32;

  // per-person frame table, one entry per person id
  localparam int unsigned TableAw    = PidW;
  localparam int unsigned TableDepth = 1 << TableAw;

  localparam logic [JointW-1:0] JointLimitReset = 8'd128;

  // result records buffered between parser and output port
  localparam int unsigned ResultDepth = 4;

  typedef enum logic [2:0] {
    PhFrame,
    PhCount,
    PhPid,
    PhJoints,
    PhWords,
    PhTailOk,
    PhTailBad
  } phase_e;

  typedef enum logic [1:0] {
    KindWord    = 2'd0,
    KindCommit  = 2'd1,
    KindDiscard = 2'd2,
    KindDone    = 2'd3
  } kind_e;

  // everything one payload byte produces, up to four result items
  typedef struct packed {
    logic              has_word;
    logic              has_commit;
    logic              has_discard;
    logic              has_done;
    logic              packet_ok;
    logic [FrameW-1:0] frame;
    logic [PidW-1:0]   pid;
    logic [IdxW-1:0]   word_index;
    logic [31:0]       word_value;
    logic [JointW-1:0] joint_total;
    logic [TotalW-1:0] rx_count;
    logic [TotalW-1:0] dr_count;
  } mpd_record_t;

  typedef struct packed {
    logic               rd_en;
    logic [TableAw-1:0] rd_addr;
    logic               wr_en;
    logic [TableAw-1:0] wr_addr;
    logic [FrameW-1:0]  wr_frame;
  } tbl_req_t;

  typedef struct packed {
    logic              busy;
    logic              hit;
    logic [FrameW-1:0] frame;
  } tbl_rsp_t;

  function automatic logic [TotalW-1:0] sat_inc(input logic [TotalW-1:0] c);
    sat_inc = (c == '1) ? c : c + TotalW'(1);
  endfunction

endpackage

// ===== hw/rtl/mpd_byte_if.sv =====
interface mpd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_packet;

  modport source (output valid, data_byte, end_of_packet, input ready);
  modport sink (input valid, data_byte, end_of_packet, output ready);
endinterface

// ===== hw/rtl/mpd_cfg_if.sv =====
interface mpd_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// ===== hw/rtl/mpd_result_if.sv =====
interface mpd_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [31:0] frame_number;
  logic [15:0] person_id;
  logic [9:0]  word_index;
  logic [31:0] word_value;
  logic [7:0]  joint_total;
  logic        packet_ok;
  logic [31:0] received_count;
  logic [31:0] dropped_count;
  logic        last_result;

  modport source (
    output valid, kind, frame_number, person_id, word_index, word_value,
           joint_total, packet_ok, received_count, dropped_count, last_result,
    input  ready
  );
  modport sink (
    input  valid, kind, frame_number, person_id, word_index, word_value,
           joint_total, packet_ok, received_count, dropped_count, last_result,
    output ready
  );
endinterface

// ===== hw/rtl/mpd_frame_table.sv =====
module mpd_frame_table (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mpd_pkg::tbl_req_t req_i,
  output mpd_pkg::tbl_rsp_t rsp_o
);

  // entry: valid bit over last committed frame id
  logic [mpd_pkg::FrameW:0] mem [mpd_pkg::TableDepth];
  logic [mpd_pkg::FrameW:0] rdata_q;

  logic                        clr_busy_q, clr_busy_d;
  logic [mpd_pkg::TableAw-1:0] clr_addr_q, clr_addr_d;

  // clearing sweep after reset, one entry per cycle
  always_comb begin
    clr_addr_d = clr_addr_q;
    clr_busy_d = clr_busy_q;
    if (clr_busy_q) begin
      clr_addr_d = clr_addr_q + mpd_pkg::TableAw'(1);
      if (clr_addr_q == '1) begin
        clr_busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else begin
      clr_busy_q <= clr_busy_d;
      clr_addr_q <= clr_addr_d;
    end
  end

  // write port
  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      mem[clr_addr_q] <= '0;
    end else if (req_i.wr_en) begin
      mem[req_i.wr_addr] <= {1'b1, req_i.wr_frame};
    end
  end

  // read port, registered data
  always_ff @(posedge clk_i) begin
    if (req_i.rd_en) begin
      rdata_q <= mem[req_i.rd_addr];
    end
  end

  assign rsp_o.busy  = clr_busy_q;
  assign rsp_o.hit   = rdata_q[mpd_pkg::FrameW];
  assign rsp_o.frame = rdata_q[mpd_pkg::FrameW-1:0];

endmodule

// ===== hw/rtl/mpd_result_queue.sv =====
module mpd_result_queue #(
  parameter int unsigned Depth = mpd_pkg::ResultDepth
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  mpd_pkg::mpd_record_t rec_i,
  output logic                 full_o,
  mpd_result_if.source         result_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  mpd_pkg::mpd_record_t entries_q [Depth];

  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic [2:0]      taken_q, taken_d;

  mpd_pkg::mpd_record_t head;
  mpd_pkg::kind_e       cur_kind;
  logic                 cur_last;
  logic                 pop_item;
  logic                 pop_rec;
  logic [31:0]          rx_end;
  logic [31:0]          dr_end;

  assign head     = entries_q[rd_ptr_q];
  assign full_o   = (count_q == CntW'(Depth));
  assign pop_item = result_o.valid && result_o.ready;
  assign pop_rec  = pop_item && cur_last;

  // pick the next pending item of the head record
  always_comb begin
    if (head.has_word && !taken_q[0]) begin
      cur_kind = mpd_pkg::KindWord;
      cur_last = !head.has_commit && !head.has_discard && !head.has_done;
    end else if (head.has_commit && !taken_q[1]) begin
      cur_kind = mpd_pkg::KindCommit;
      cur_last = !head.has_discard && !head.has_done;
    end else if (head.has_discard && !taken_q[2]) begin
      cur_kind = mpd_pkg::KindDiscard;
      cur_last = !head.has_done;
    end else begin
      cur_kind = mpd_pkg::KindDone;
      cur_last = 1'b1;
    end
  end

  // totals after the packet count on packet done
  assign rx_end = head.packet_ok ? mpd_pkg::sat_inc(head.rx_count) : head.rx_count;
  assign dr_end = head.packet_ok ? head.dr_count : mpd_pkg::sat_inc(head.dr_count);

  // output fields
  always_comb begin
    result_o.valid          = (count_q != '0);
    result_o.kind           = cur_kind;
    result_o.frame_number   = head.frame;
    result_o.person_id      = (cur_kind == mpd_pkg::KindDone) ? 16'd0 : head.pid;
    result_o.word_index     = (cur_kind == mpd_pkg::KindWord) ? head.word_index : 10'd0;
    result_o.word_value     = (cur_kind == mpd_pkg::KindWord) ? head.word_value : 32'd0;
    result_o.joint_total    = (cur_kind == mpd_pkg::KindCommit) ? head.joint_total : 8'd0;
    result_o.packet_ok      = (cur_kind == mpd_pkg::KindDone) ? head.packet_ok : 1'b0;
    result_o.received_count = (cur_kind == mpd_pkg::KindDone) ? rx_end : head.rx_count;
    result_o.dropped_count  = (cur_kind == mpd_pkg::KindDone) ? dr_end : head.dr_count;
    result_o.last_result    = cur_last;
  end

  // pointers, fill count and per-record progress
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    taken_d  = taken_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_rec) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      taken_d  = '0;
    end else if (pop_item) begin
      case (cur_kind)
        mpd_pkg::KindWord:    taken_d[0] = 1'b1;
        mpd_pkg::KindCommit:  taken_d[1] = 1'b1;
        mpd_pkg::KindDiscard: taken_d[2] = 1'b1;
        default:              taken_d    = taken_q;
      endcase
    end
    case ({push_i, pop_rec})
      2'b10:   count_d = count_q + CntW'(1);
      2'b01:   count_d = count_q - CntW'(1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
      taken_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
      taken_q  <= taken_d;
    end
  end

  // record storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= rec_i;
    end
  end

endmodule

// ===== hw/rtl/motion_packet_deframer_top.sv =====
// channel   | dir | signals                                  | item
// ----------+-----+------------------------------------------+---------------------------
// byte_i    | in  | valid ready data_byte end_of_packet      | one payload byte
// cfg_i     | in  | valid ready data                         | joint_limit write
// result_o  | out | valid ready kind frame_number ... last   | one parsed result
//
// One byte is taken per cycle while byte_i.ready is high; the parser does all work for a byte in that cycle.
// A byte yields zero to four items; they leave one per cycle while result_o.ready is high, from a small record queue,
// and input stalls only when that queue is full or while the table is being cleared.
// The person table lookup is read on the second person id byte and used on the joint byte.
// After reset all 65536 entries of the person table are cleared, with byte_i.ready low.
// cfg_i is always ready; reset sets joint_limit to 128.
module motion_packet_deframer_top #(
  parameter int unsigned ResultDepth = mpd_pkg::ResultDepth
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  mpd_byte_if.sink     byte_i,
  mpd_cfg_if.sink      cfg_i,
  mpd_result_if.source result_o
);

  mpd_pkg::phase_e phase_q, phase_d, phase_nat;

  logic [1:0]  fbc_q, fbc_d;
  logic [31:0] frame_q, frame_d;
  logic [7:0]  persons_q, persons_d;
  logic [15:0] person_q, person_d;
  logic [7:0]  joints_q, joints_d;
  logic [9:0]  word_pos_q, word_pos_d;
  logic [31:0] word_asm_q, word_asm_d;
  logic        stale_q, stale_d;
  logic [31:0] rx_q, rx_d;
  logic [31:0] dr_q, dr_d;
  logic [7:0]  limit_q;

  logic        accept;
  logic [7:0]  b;
  logic        eop;
  logic [31:0] frame_asm;
  logic [31:0] word_new;
  logic [9:0]  last_word;
  logic        word_complete;
  logic        is_last_word;
  logic [7:0]  persons_dec;
  logic [31:0] dr_mid;

  logic mal, fin_en, fin_ok;
  logic emit_word, emit_commit, stale_done, pid_done, joints_ok;

  mpd_pkg::tbl_req_t    tbl_req;
  mpd_pkg::tbl_rsp_t    tbl_rsp;
  mpd_pkg::mpd_record_t rec;
  logic                 q_full;
  logic                 push;

  assign b      = byte_i.data_byte;
  assign eop    = byte_i.end_of_packet;
  assign accept = byte_i.valid && byte_i.ready;

  assign byte_i.ready = !tbl_rsp.busy && !q_full;

  // configuration register
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= mpd_pkg::JointLimitReset;
    end else if (cfg_i.valid) begin
      limit_q <= cfg_i.data;
    end
  end

  // little-endian assembly of multi-byte fields
  assign frame_asm = (fbc_q == 2'd0) ? 32'(b) : (frame_q | (32'(b) << {fbc_q, 3'b000}));
  assign word_new  = (fbc_q == 2'd0) ? 32'(b) : (word_asm_q | (32'(b) << {fbc_q, 3'b000}));

  assign last_word     = {joints_q, 2'b10};
  assign word_complete = (fbc_q == 2'd3);
  assign is_last_word  = (word_pos_q >= last_word);
  assign persons_dec   = persons_q - 8'd1;

  // per-byte events
  always_comb begin
    phase_nat   = phase_q;
    mal         = 1'b0;
    fin_en      = 1'b0;
    fin_ok      = 1'b0;
    emit_word   = 1'b0;
    emit_commit = 1'b0;
    stale_done  = 1'b0;
    pid_done    = 1'b0;
    joints_ok   = 1'b0;
    unique case (phase_q)
      mpd_pkg::PhFrame: begin
        if (fbc_q == 2'd3) begin
          phase_nat = mpd_pkg::PhCount;
        end
        fin_en = eop;
      end
      mpd_pkg::PhCount: begin
        phase_nat = (b != 8'd0) ? mpd_pkg::PhPid : mpd_pkg::PhTailOk;
        fin_en    = eop;
        fin_ok    = (b == 8'd0);
      end
      mpd_pkg::PhPid: begin
        if (fbc_q != 2'd0) begin
          pid_done  = 1'b1;
          phase_nat = mpd_pkg::PhJoints;
        end
        mal = eop;
      end
      mpd_pkg::PhJoints: begin
        if (b == 8'd0 || b > limit_q) begin
          mal = 1'b1;
        end else begin
          joints_ok = 1'b1;
          phase_nat = mpd_pkg::PhWords;
          mal       = eop;
        end
      end
      mpd_pkg::PhWords: begin
        if (word_complete) begin
          emit_word = !stale_q;
          if (is_last_word) begin
            emit_commit = !stale_q;
            stale_done  = stale_q;
            phase_nat   = (persons_dec != 8'd0) ? mpd_pkg::PhPid : mpd_pkg::PhTailOk;
          end
        end
        if (eop) begin
          if (phase_nat == mpd_pkg::PhTailOk) begin
            fin_en = 1'b1;
            fin_ok = 1'b1;
          end else begin
            mal = 1'b1;
          end
        end
      end
      mpd_pkg::PhTailOk: begin
        fin_en = eop;
        fin_ok = 1'b1;
      end
      default: begin
        fin_en = eop;
      end
    endcase
    // a malformed end still finishes the packet as dropped
    if (mal && eop) begin
      fin_en = 1'b1;
      fin_ok = 1'b0;
    end
  end

  // next phase
  always_comb begin
    phase_d = phase_q;
    if (accept) begin
      if (fin_en) begin
        phase_d = mpd_pkg::PhFrame;
      end else if (mal) begin
        phase_d = mpd_pkg::PhTailBad;
      end else begin
        phase_d = phase_nat;
      end
    end
  end

  // field registers and counters
  always_comb begin
    fbc_d      = fbc_q;
    frame_d    = frame_q;
    persons_d  = persons_q;
    person_d   = person_q;
    joints_d   = joints_q;
    word_pos_d = word_pos_q;
    word_asm_d = word_asm_q;
    stale_d    = stale_q;
    case (phase_q)
      mpd_pkg::PhFrame: begin
        frame_d = frame_asm;
        fbc_d   = fbc_q + 2'd1;
      end
      mpd_pkg::PhCount: begin
        persons_d = b;
        fbc_d     = 2'd0;
      end
      mpd_pkg::PhPid: begin
        if (fbc_q == 2'd0) begin
          person_d = {8'h00, b};
          fbc_d    = 2'd1;
        end else begin
          person_d = {b, person_q[7:0]};
          fbc_d    = 2'd0;
        end
      end
      mpd_pkg::PhJoints: begin
        if (joints_ok) begin
          joints_d   = b;
          stale_d    = tbl_rsp.hit && (tbl_rsp.frame >= frame_q);
          word_pos_d = '0;
          word_asm_d = '0;
          fbc_d      = 2'd0;
        end
      end
      mpd_pkg::PhWords: begin
        word_asm_d = word_new;
        fbc_d      = fbc_q + 2'd1;
        if (word_complete) begin
          if (is_last_word) begin
            persons_d = persons_dec;
          end else begin
            word_pos_d = word_pos_q + 10'd1;
          end
        end
      end
      default: begin
        fbc_d = fbc_q;
      end
    endcase
    if (fin_en) begin
      fbc_d   = 2'd0;
      frame_d = '0;
    end
  end

  assign dr_mid = stale_done ? mpd_pkg::sat_inc(dr_q) : dr_q;
  assign rx_d   = (fin_en && fin_ok) ? mpd_pkg::sat_inc(rx_q) : rx_q;
  assign dr_d   = (fin_en && !fin_ok) ? mpd_pkg::sat_inc(dr_mid) : dr_mid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= mpd_pkg::PhFrame;
      fbc_q      <= '0;
      frame_q    <= '0;
      persons_q  <= '0;
      person_q   <= '0;
      joints_q   <= '0;
      word_pos_q <= '0;
      word_asm_q <= '0;
      stale_q    <= 1'b0;
      rx_q       <= '0;
      dr_q       <= '0;
    end else begin
      phase_q <= phase_d;
      if (accept) begin
        fbc_q      <= fbc_d;
        frame_q    <= frame_d;
        persons_q  <= persons_d;
        person_q   <= person_d;
        joints_q   <= joints_d;
        word_pos_q <= word_pos_d;
        word_asm_q <= word_asm_d;
        stale_q    <= stale_d;
        rx_q       <= rx_d;
        dr_q       <= dr_d;
      end
    end
  end

  // table lookup on the second id byte, update on commit
  always_comb begin
    tbl_req.rd_en    = accept && pid_done;
    tbl_req.rd_addr  = {b, person_q[7:0]};
    tbl_req.wr_en    = accept && emit_commit;
    tbl_req.wr_addr  = person_q;
    tbl_req.wr_frame = frame_q;
  end

  mpd_frame_table u_table (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (tbl_req),
    .rsp_o  (tbl_rsp)
  );

  // result record for this byte
  assign push = accept && (emit_word || emit_commit || mal || fin_en);

  always_comb begin
    rec.has_word    = emit_word;
    rec.has_commit  = emit_commit;
    rec.has_discard = mal;
    rec.has_done    = fin_en;
    rec.packet_ok   = fin_ok;
    rec.frame       = (phase_q == mpd_pkg::PhFrame) ? frame_asm : frame_q;
    rec.pid         = person_d;
    rec.word_index  = word_pos_q;
    rec.word_value  = word_new;
    rec.joint_total = joints_q;
    rec.rx_count    = rx_q;
    rec.dr_count    = dr_mid;
  end

  mpd_result_queue #(
    .Depth (ResultDepth)
  ) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .rec_i    (rec),
    .full_o   (q_full),
    .result_o (result_o)
  );

endmodule
